// ===== hdl/pss_pkg.sv =====
`timescale 1ns / 1ps
package pss_pkg;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int TIME_BITS_DEF = 48;
    localparam int WORK_BITS_DEF = 32;
    localparam int TAG_W = 8;
    localparam int TIME_FIELD_W = 48;
    localparam int WORK_FIELD_W = 32;
    localparam int QLEN_W = 5;

    typedef enum logic [1:0] {
        ERR_OK = 2'd0,
        ERR_FULL = 2'd1,
        ERR_UNKNOWN = 2'd2
    } err_t;

    localparam logic OP_ARRIVE = 1'b0;
    localparam logic OP_COMPLETE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SCAN,
        ST_MIN,
        ST_MUL,
        ST_FIN,
        ST_OUT
    } state_t;
endpackage

// ===== hdl/pss_divider.sv =====
`timescale 1ns / 1ps
module pss_divider #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 9
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] numer,
    input  logic [DEN_W-1:0] denom,
    output logic             done,
    output logic [NUM_W-1:0] quot
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] q_reg, q_next;
    logic [DEN_W:0]   r_reg, r_next;
    logic [DEN_W-1:0] d_reg, d_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [DEN_W:0]   trial;

    // restoring division, one quotient bit per cycle
    always_comb begin
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        trial = {r_reg[DEN_W-1:0], q_reg[NUM_W-1]};
        if (start) begin
            q_next = numer;
            r_next = '0;
            d_next = denom;
            cnt_next = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, d_reg}) begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[NUM_W-2:0], 1'b1};
            end else begin
                r_next = trial;
                q_next = {q_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
        cnt_reg <= cnt_next;
        if (!aresetn) busy_reg <= 1'b0;
        else busy_reg <= busy_next;
    end

    assign done = busy_reg && (cnt_reg == CNT_W'(1));
    assign quot = q_next;
endmodule

// ===== hdl/processor_sharing_scheduler.sv =====
`timescale 1ns / 1ps
// channel | dir | fields (lsb first)
// s_axis  | in  | tuser: opcode; tdata: job_tag, now_time, job_work
// m_axis  | out | tdata: next_valid, next_tag, next_finish_time, queue_length,
//         |     |       completed_valid, completed_tag, error_code, zero fill
// one event runs from one input transfer to the next through these steps: divider
// start and the bit-serial divider for the aging share (skipped with an empty table),
// one table slot per cycle for aging/insert/remove, one slot per cycle for the
// minimum search, then multiply, finish, output and idle
// reset clears valid bits, job count and last time; slot contents are not cleared
// s_axis_tready is low while an event is in work; the result sits in an output
// register until taken, and the next event is accepted in that wait; a later event
// holds in its output step until that register frees
module processor_sharing_scheduler #(
    parameter int QUEUE_DEPTH = pss_pkg::QUEUE_DEPTH_DEF,
    parameter int TIME_BITS = pss_pkg::TIME_BITS_DEF,
    parameter int WORK_BITS = pss_pkg::WORK_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [0:0]   s_axis_tuser,   // opcode
    input  logic [87:0]  s_axis_tdata,   // job_tag, now_time, job_work
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [79:0]  m_axis_tdata    // next_valid, next_tag, next_finish_time,
                                         // queue_length, completed_valid,
                                         // completed_tag, error_code, zero fill
);
    import pss_pkg::*;

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int PROD_W = WORK_BITS + CNT_W;
    localparam int CMP_W = (TIME_BITS > WORK_BITS) ? TIME_BITS : WORK_BITS;
    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    state_t state_reg, state_next;

    // table: valid bits in flops, tag and remaining work in memories
    logic [QUEUE_DEPTH-1:0] valid_reg;
    logic [TAG_W-1:0]       tag_mem [QUEUE_DEPTH];
    logic [WORK_BITS-1:0]   rem_mem [QUEUE_DEPTH];

    logic [CNT_W-1:0]     count_reg;
    logic [TIME_BITS-1:0] last_reg;

    // captured event
    logic                 op_reg;
    logic [TAG_W-1:0]     etag_reg;
    logic [TIME_BITS-1:0] now_reg;
    logic [WORK_BITS-1:0] ework_reg;

    logic [TIME_BITS-1:0] share_reg;
    logic [IDX_W:0]       idx_reg;
    logic                 found_reg;
    logic                 free_found_reg;
    logic [IDX_W-1:0]     free_reg;
    logic                 best_ok_reg;
    logic [WORK_BITS-1:0] best_rem_reg;
    logic [TAG_W-1:0]     best_tag_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [TIME_BITS-1:0] fin_reg;
    logic [1:0]           err_reg;
    logic                 cvalid_reg;

    logic [79:0]          out_reg;
    logic [79:0]          out_word;
    logic                 out_valid_reg;

    // divider
    logic                 div_start, div_done;
    logic [TIME_BITS-1:0] elapsed, div_q;
    logic [TIME_BITS-1:0] now_in;
    logic [WORK_BITS-1:0] work_in;

    assign now_in = TIME_BITS'(s_axis_tdata[8 +: TIME_FIELD_W]);
    assign work_in = WORK_BITS'(s_axis_tdata[56 +: WORK_FIELD_W]);
    assign elapsed = (now_reg >= last_reg) ? (now_reg - last_reg) : '0;

    pss_divider #(.NUM_W(TIME_BITS), .DEN_W(CNT_W)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .numer(elapsed), .denom(count_reg), .done(div_done), .quot(div_q)
    );

    logic s_fire, o_free;
    assign o_free = !out_valid_reg || m_axis_tready;
    assign s_fire = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_reg;

    logic [IDX_W-1:0] idx;
    logic             last_idx;
    assign idx = idx_reg[IDX_W-1:0];
    assign last_idx = (idx_reg == (IDX_W+1)'(QUEUE_DEPTH - 1));

    // read of current slot (combinational read of small table)
    logic [WORK_BITS-1:0] rd_rem;
    logic [TAG_W-1:0]     rd_tag;
    assign rd_rem = rem_mem[idx];
    assign rd_tag = tag_mem[idx];

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_fire) state_next = ST_DIV;
            ST_DIV:  if (count_reg == '0 || div_done) state_next = ST_SCAN;
            ST_SCAN: if (last_idx) state_next = ST_MIN;
            ST_MIN:  if (last_idx) state_next = ST_MUL;
            ST_MUL:  state_next = ST_FIN;
            ST_FIN:  state_next = ST_OUT;
            ST_OUT:  if (o_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath control
    logic div_started_reg;
    assign div_start = (state_reg == ST_DIV) && !div_started_reg && (count_reg != '0);

    logic [TIME_BITS-1:0] span, fin;
    assign span = TIME_BITS'(prod_reg);
    logic span_big;
    always_comb begin
        span_big = 1'b0;
        if (PROD_W > TIME_BITS)
            span_big = (prod_reg >> TIME_BITS) != '0;
        fin = (span_big || span > (TIME_MAX - now_reg)) ? TIME_MAX : now_reg + span;
    end

    logic [WORK_BITS-1:0] aged;
    always_comb begin
        if (CMP_W'(rd_rem) > CMP_W'(share_reg)) aged = rd_rem - WORK_BITS'(share_reg);
        else aged = '0;
    end

    // result word, fields from the lowest bit up
    always_comb begin
        out_word = '0;
        out_word[0] = best_ok_reg;
        if (best_ok_reg) begin
            out_word[8:1] = best_tag_reg;
            out_word[56:9] = TIME_FIELD_W'(fin_reg);
        end
        out_word[61:57] = QLEN_W'(count_reg);
        out_word[62] = cvalid_reg;
        if (cvalid_reg) out_word[70:63] = etag_reg;
        out_word[72:71] = err_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= '0;
            count_reg <= '0;
            last_reg <= '0;
            out_valid_reg <= 1'b0;
            div_started_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_OUT && o_free) out_valid_reg <= 1'b1;
            else if (m_axis_tready) out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        op_reg <= s_axis_tuser[0];
                        etag_reg <= s_axis_tdata[7:0];
                        now_reg <= now_in;
                        ework_reg <= work_in;
                        div_started_reg <= 1'b0;
                    end
                end
                ST_DIV: begin
                    if (div_start) div_started_reg <= 1'b1;
                    share_reg <= (count_reg == '0) ? '0 : div_q;
                    idx_reg <= '0;
                    found_reg <= 1'b0;
                    free_found_reg <= 1'b0;
                    free_reg <= '0;
                end
                ST_SCAN: begin
                    if (valid_reg[idx]) rem_mem[idx] <= aged;
                    if (!valid_reg[idx] && !free_found_reg) begin
                        free_found_reg <= 1'b1;
                        free_reg <= idx;
                    end
                    if (op_reg == OP_COMPLETE && valid_reg[idx] && !found_reg
                        && rd_tag == etag_reg) begin
                        found_reg <= 1'b1;
                        valid_reg[idx] <= 1'b0;
                        count_reg <= count_reg - 1'b1;
                    end
                    if (last_idx) begin
                        last_reg <= now_reg;
                        idx_reg <= '0;
                        best_ok_reg <= 1'b0;
                        cvalid_reg <= 1'b0;
                        err_reg <= ERR_OK;
                        if (op_reg == OP_ARRIVE) begin
                            if (!valid_reg[idx] || free_found_reg) begin
                                if (free_found_reg) begin
                                    valid_reg[free_reg] <= 1'b1;
                                    tag_mem[free_reg] <= etag_reg;
                                    rem_mem[free_reg] <= ework_reg;
                                end else begin
                                    valid_reg[idx] <= 1'b1;
                                    tag_mem[idx] <= etag_reg;
                                    rem_mem[idx] <= ework_reg;
                                end
                                count_reg <= count_reg + 1'b1;
                            end else begin
                                err_reg <= ERR_FULL;
                            end
                        end else begin
                            if (found_reg || (valid_reg[idx] && rd_tag == etag_reg))
                                cvalid_reg <= 1'b1;
                            else
                                err_reg <= ERR_UNKNOWN;
                        end
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_MIN: begin
                    if (valid_reg[idx] && (!best_ok_reg || rd_rem < best_rem_reg)) begin
                        best_ok_reg <= 1'b1;
                        best_rem_reg <= rd_rem;
                        best_tag_reg <= rd_tag;
                    end
                    if (!last_idx) idx_reg <= idx_reg + 1'b1;
                end
                ST_MUL: prod_reg <= PROD_W'(best_rem_reg) * PROD_W'(count_reg);
                ST_FIN: fin_reg <= fin;
                ST_OUT: begin
                    // load only once the previous result has left
                    if (o_free) out_reg <= out_word;
                end
                default: ;
            endcase
        end
    end
endmodule
